### rtl/mi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_pkg: modular inverse shared definitions
// Word width, beat payloads and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package mi_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(WIDTH - 1);

    typedef struct packed {
        logic [WIDTH-1:0] value;
        logic [WIDTH-1:0] modulus;
    } in_beat_t;

    typedef struct packed {
        logic [WIDTH-1:0] inverse;
        logic             exists;
    } out_beat_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic update;
        logic finish;
    } mi_cmd_t;

    typedef struct packed {
        logic nr_zero;
        logic out_free;
    } mi_status_t;

endpackage

### rtl/mi_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_in_if: operand channel
// Valid/ready channel carrying one value and modulus per beat.
// ----------------------------------------------------------------------------
interface mi_in_if
    import mi_pkg::*;
;
    logic     valid;
    logic     ready;
    in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/mi_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_out_if: result channel
// Valid/ready channel carrying one inverse and existence flag per beat.
// ----------------------------------------------------------------------------
interface mi_out_if
    import mi_pkg::*;
;
    logic      valid;
    logic      ready;
    out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/modular_inverse_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_top: modular inverse by extended Euclid
// Returns value^-1 mod modulus and a flag saying whether it exists.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat carries value and modulus. in_ch.ready is high only
//            while the block is idle; one operand pair is worked at a time.
//   out_ch : one beat per operand pair, inverse and exists. The result sits
//            in an output register, so the next pair may be accepted while
//            it waits to be taken.
//   Divide : each Euclid division step is a bit-serial restoring divide with
//            the quotient multiply folded in by shift-and-add, plus a
//            remainder test and a coefficient update. The number of division
//            steps is up to about 1.44*WIDTH, 46 for 32-bit words.
//   Reset  : rst_n clears the sequencer and the output valid; no result is
//            pending afterwards.
//   Stall  : while out_ch.ready is low a finished result holds; a following
//            computation completes and then waits for the register to free.
// ----------------------------------------------------------------------------
module modular_inverse_top
    import mi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    mi_in_if.sink    in_ch,
    mi_out_if.source out_ch
);

    mi_cmd_t    cmd;
    mi_status_t status;
    logic       ready;
    logic       out_valid;
    out_beat_t  out_data;

    mi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (ready),
        .status   (status),
        .cmd      (cmd)
    );

    mi_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_ch.data),
        .out_ready (out_ch.ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign in_ch.ready  = ready;
    assign out_ch.valid = out_valid;
    assign out_ch.data  = out_data;

endmodule

### rtl/mi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_datapath: extended Euclid datapath
// Remainder pair, coefficient magnitudes, a bit-serial restoring divider
// with a shift-and-add quotient multiply, and the result register.
// ----------------------------------------------------------------------------
module mi_datapath
    import mi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mi_cmd_t    cmd,
    output mi_status_t status,
    input  in_beat_t   in_data,
    input  logic       out_ready,
    output logic       out_valid,
    output out_beat_t  out_data
);

    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] nr_reg, nr_next;
    logic [WIDTH-1:0] tm_reg, tm_next;
    logic [WIDTH-1:0] ntm_reg, ntm_next;
    logic [WIDTH-1:0] n_reg, n_next;
    logic             neg_reg, neg_next;
    logic [WIDTH-1:0] p_reg, p_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic             out_valid_reg, out_valid_next;
    out_beat_t        out_data_reg, out_data_next;

    logic [WIDTH:0]   trial;
    logic             q_bit;
    logic [WIDTH-1:0] inv;

    assign trial = {p_reg, d_reg[WIDTH-1]} - {1'b0, nr_reg};
    assign q_bit = ~trial[WIDTH];
    assign inv   = (neg_reg && (tm_reg != '0)) ? (n_reg - tm_reg) : tm_reg;

    always_comb
    begin
        r_next   = r_reg;
        nr_next  = nr_reg;
        tm_next  = tm_reg;
        ntm_next = ntm_reg;
        n_next   = n_reg;
        neg_next = neg_reg;
        p_next   = p_reg;
        d_next   = d_reg;
        acc_next = acc_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg & ~out_ready;

        if (cmd.load)
        begin
            r_next   = in_data.modulus;
            nr_next  = in_data.value;
            n_next   = in_data.modulus;
            tm_next  = '0;
            ntm_next = WIDTH'(1);
            neg_next = 1'b1;
        end
        if (cmd.div_init)
        begin
            p_next   = '0;
            d_next   = r_reg;
            acc_next = '0;
        end
        if (cmd.div_step)
        begin
            p_next   = q_bit ? trial[WIDTH-1:0] : {p_reg[WIDTH-2:0], d_reg[WIDTH-1]};
            d_next   = {d_reg[WIDTH-2:0], 1'b0};
            acc_next = {acc_reg[WIDTH-2:0], 1'b0} + (q_bit ? ntm_reg : '0);
        end
        if (cmd.update)
        begin
            r_next   = nr_reg;
            nr_next  = p_reg;
            tm_next  = ntm_reg;
            ntm_next = tm_reg + acc_reg;
            neg_next = ~neg_reg;
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            if (|r_reg[WIDTH-1:1])
            begin
                out_data_next.inverse = '0;
                out_data_next.exists  = 1'b0;
            end
            else
            begin
                out_data_next.inverse = inv;
                out_data_next.exists  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        nr_reg       <= nr_next;
        tm_reg       <= tm_next;
        ntm_reg      <= ntm_next;
        n_reg        <= n_next;
        neg_reg      <= neg_next;
        p_reg        <= p_next;
        d_reg        <= d_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign status.nr_zero  = (nr_reg == '0);
    assign status.out_free = ~out_valid_reg | out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

### rtl/mi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_ctrl: extended Euclid sequencer
// Walks accept, remainder test, bit-serial divide and coefficient update,
// then hands the result to the output register once it is free.
// ----------------------------------------------------------------------------
module mi_ctrl
    import mi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  mi_status_t status,
    output mi_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.nr_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == LAST_BIT)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_CHECK;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### rtl/mi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_checker: port-level checks for modular_inverse_top
// Watches both channels and checks busy, result and stall behaviour.
// ----------------------------------------------------------------------------
module mi_checker
    import mi_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [WIDTH-1:0] out_inverse,
    input logic             out_exists
);

    // busy straight after an accepted beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while previous pair still in work");

    // no inverse without the flag
    a_zero_when_absent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_exists) |-> (out_inverse == '0))
        else $error("non-zero inverse with exists clear");

    // a new result only ever follows a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a computation");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_inverse) && $stable(out_exists)))
        else $error("stalled result beat changed");

endmodule

bind modular_inverse_top mi_checker u_mi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_inverse (out_ch.data.inverse),
    .out_exists  (out_ch.data.exists)
);

### test/modular_inverse_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_top_test: self-checking bench for the modular inverse block
// Feeds operand pairs through the input channel in random bursts. Each
// accepted pair is run through a local extended Euclid predictor. Every
// result beat is checked field by field against the oldest prediction.
// The result side stalls on its own pattern and once holds off for a long
// stretch.
// ----------------------------------------------------------------------------
module modular_inverse_top_test;
    import mi_pkg::*;

    localparam int    MAX_LAT    = 3 + 48 * (WIDTH + 2);
    localparam int    RANDOM_CNT = 1930;
    localparam int    GAP_MAX    = 40;
    localparam int    HOLD_LEN   = 4 * MAX_LAT;
    localparam int    HOLD_AT    = 40;
    localparam longint LIMIT     = 4 * (longint'(RANDOM_CNT + 25)
                                   * (MAX_LAT + GAP_MAX + 64) + HOLD_LEN) + 10000;

    logic clk;
    logic rst_n;

    mi_in_if  in_ch ();
    mi_out_if out_ch ();

    modular_inverse_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    in_beat_t  pending_pairs[$];
    out_beat_t expected_results[$];
    int        mismatches   = 0;
    int        results_seen = 0;
    longint    cycle_count  = 0;
    int        burst_left   = 1;
    int        gap_left     = 0;
    int        hold_left    = 0;
    bit        held         = 0;
    int        rx_mode      = 0;
    int        rx_phase     = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // extended Euclid, Bezout magnitude with sign from step parity
    function automatic out_beat_t inverse_of(in_beat_t pair);
        logic [WIDTH-1:0]   r;
        logic [WIDTH-1:0]   nr;
        logic [WIDTH-1:0]   q;
        logic [WIDTH-1:0]   rem;
        logic [2*WIDTH-1:0] tm;
        logic [2*WIDTH-1:0] ntm;
        logic [2*WIDTH-1:0] nm;
        bit                 t_neg;
        out_beat_t          res;
        r     = pair.modulus;
        nr    = pair.value;
        tm    = '0;
        ntm   = (2*WIDTH)'(1);
        t_neg = 1'b1;
        while (nr != 0)
        begin
            q     = r / nr;
            rem   = r % nr;
            nm    = tm + (2*WIDTH)'(q) * ntm;
            r     = nr;
            nr    = rem;
            tm    = ntm;
            ntm   = nm;
            t_neg = !t_neg;
        end
        if (r > 1)
        begin
            res.inverse = '0;
            res.exists  = 1'b0;
        end
        else
        begin
            if (t_neg && tm != 0)
                res.inverse = WIDTH'((2*WIDTH)'(pair.modulus) - tm);
            else
                res.inverse = WIDTH'(tm);
            res.exists = 1'b1;
        end
        return res;
    endfunction

    // driver: bursts of beats with random gaps, valid held until taken
    always @(posedge clk or negedge rst_n)
    begin
        bit accepted;
        bit offer;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            burst_left  <= 1;
            gap_left    <= 0;
        end
        else
        begin
            accepted = in_ch.valid && in_ch.ready;
            if (accepted)
            begin
                expected_results.push_back(inverse_of(in_ch.data));
                void'(pending_pairs.pop_front());
            end
            if (in_ch.valid && !accepted)
                offer = 1'b1;
            else if (gap_left > 0)
            begin
                offer = 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_pairs.size() > 0)
            begin
                offer = 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 6);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0
                                  : $urandom_range(1, GAP_MAX);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                offer = 1'b0;
            in_ch.valid <= offer;
            if (offer && !(in_ch.valid && !accepted))
                in_ch.data <= pending_pairs[0];
        end
    end

    // receiver: mode changes every so often, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
            held         <= 1'b0;
            rx_mode      <= 0;
            rx_phase     <= 0;
        end
        else if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (!held && results_seen == HOLD_AT)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_LEN;
            held         <= 1'b1;
        end
        else
        begin
            if (rx_phase == 0)
            begin
                rx_mode  <= $urandom_range(0, 2);
                rx_phase <= $urandom_range(50, 3000);
            end
            else
                rx_phase <= rx_phase - 1;
            case (rx_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= 1'($urandom_range(0, 1));
                default: out_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_beat_t want;
        int        errs;
        errs = 0;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected beat inverse=%h exists=%b", $time,
                         out_ch.data.inverse, out_ch.data.exists);
                errs = errs + 1;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_ch.data.inverse !== want.inverse)
                begin
                    $display("%0t: inverse expected %h actual %h", $time,
                             want.inverse, out_ch.data.inverse);
                    errs = errs + 1;
                end
                if (out_ch.data.exists !== want.exists)
                begin
                    $display("%0t: exists expected %b actual %b", $time,
                             want.exists, out_ch.data.exists);
                    errs = errs + 1;
                end
            end
        end
        if (errs != 0)
            mismatches <= mismatches + errs;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        in_beat_t         p;
        logic [WIDTH-1:0] g;
        rst_n        = 1'b0;

        // directed: field extremes and corner cases
        pending_pairs.push_back('{value: 0,            modulus: 0});
        pending_pairs.push_back('{value: 1,            modulus: 0});
        pending_pairs.push_back('{value: 5,            modulus: 0});
        pending_pairs.push_back('{value: '1,           modulus: 0});
        pending_pairs.push_back('{value: 0,            modulus: 1});
        pending_pairs.push_back('{value: '1,           modulus: 1});
        pending_pairs.push_back('{value: 0,            modulus: 7});
        pending_pairs.push_back('{value: 0,            modulus: '1});
        pending_pairs.push_back('{value: 6,            modulus: 9});
        pending_pairs.push_back('{value: 3,            modulus: 7});
        pending_pairs.push_back('{value: 10,           modulus: 7});
        pending_pairs.push_back('{value: 7,            modulus: 7});
        pending_pairs.push_back('{value: '1,           modulus: '1});
        pending_pairs.push_back('{value: 32'hFFFFFFFE, modulus: '1});
        pending_pairs.push_back('{value: 1,            modulus: '1});
        pending_pairs.push_back('{value: 2,            modulus: '1});
        pending_pairs.push_back('{value: 1836311903,   modulus: 2971215073});
        pending_pairs.push_back('{value: 2971215073,   modulus: 1836311903});
        pending_pairs.push_back('{value: 32'hAAAAAAAA, modulus: 32'h55555555});
        pending_pairs.push_back('{value: 32'h12345679, modulus: 32'hFFFFFFFB});
        pending_pairs.push_back('{value: '1,           modulus: 32'hFFFFFFFB});
        pending_pairs.push_back('{value: 2,            modulus: 4});
        pending_pairs.push_back('{value: 1,            modulus: 2});

        for (int i = 0; i < RANDOM_CNT; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    p.value   = $urandom;
                    p.modulus = $urandom;
                end
                3, 4:
                begin
                    p.value   = $urandom;
                    p.modulus = $urandom | 1;
                end
                5:
                begin
                    p.value   = $urandom_range(0, 255);
                    p.modulus = $urandom_range(0, 255);
                end
                6:
                begin
                    p.modulus = $urandom_range(2, 65535);
                    p.value   = p.modulus + $urandom_range(0, 1000);
                end
                7:
                begin
                    g         = $urandom_range(2, 1000);
                    p.value   = g * $urandom_range(0, 32'hFFFFFFFF / g);
                    p.modulus = g * $urandom_range(1, 32'hFFFFFFFF / g);
                end
                8:
                begin
                    p.value   = ($urandom_range(0, 1) == 0) ? $urandom
                                : $urandom_range(0, 2);
                    p.modulus = $urandom_range(0, 1);
                end
                default:
                begin
                    p.value   = $urandom;
                    p.modulus = 32'hFFFFFFFB;
                end
            endcase
            pending_pairs.push_back(p);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pairs.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (MAX_LAT + 100) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
